// File: rtl/core/assert_macros.svh
// Assertion macros shared by the prefix code decoder RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define PCBD_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcbd assertion failed");

// next-cycle implication, off during reset
`define PCBD_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcbd assertion failed");

`endif

// File: rtl/core/pcbd_pkg.sv
// Package for the prefix code decoder: widths, stream layout, codes,
// controller states and the command/status structs. No dependencies.
`default_nettype none

package pcbd_pkg;

  localparam int ACC_W  = 16;
  localparam int LEN_W  = 5;
  localparam int SYM_W  = 8;
  localparam int BYTE_W = 8;
  localparam int PAD_W  = 3;
  localparam int BCNT_W = 4;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int MAX_CODE_LEN_DEF  = 16;

  // input tdata: code_bits, code_length, entry_symbol, data_byte, zero fill
  localparam int IN_CODE_LSB = 0;
  localparam int IN_LEN_LSB  = IN_CODE_LSB + ACC_W;
  localparam int IN_SYM_LSB  = IN_LEN_LSB + LEN_W;
  localparam int IN_BYTE_LSB = IN_SYM_LSB + SYM_W;
  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_TUSER_W = 2;
  localparam int OUT_OVF_BIT  = 0;
  localparam int OUT_FULL_BIT = 1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DATA = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LSTART,
    S_LWALK,
    S_LTARGET,
    S_LCHAIN,
    S_DSTART,
    S_REWALK,
    S_BITS,
    S_FLUSH
  } pcbd_state_t;

  typedef struct packed {
    logic cap;
    logic l_start;
    logic l_walk;
    logic l_target;
    logic l_chain;
    logic d_start;
    logic rewalk;
    logic bits_step;
    logic d_end;
    logic flush;
  } pcbd_cmd_t;

  typedef struct packed {
    logic len_ok;
    logic walk_fall;
    logic walk_last;
    logic chain_last;
    logic table_full;
    logic dead;
    logic bits_done;
    logic step_ok;
    logic out_free;
    logic held_valid;
  } pcbd_status_t;

endpackage

`default_nettype wire

// File: rtl/core/pcbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pcbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/pcbd_datapath.sv
// Datapath of the prefix code decoder: code trie in node RAM, walk and
// decode registers, result holding stage and output register.
// Depends on pcbd_pkg, pcbd_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pcbd_datapath import pcbd_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int MAX_CODE_LEN  = MAX_CODE_LEN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pcbd_cmd_t         cmd,
  output pcbd_status_t           st,
  input  wire logic [ACC_W-1:0]  in_code,
  input  wire logic [LEN_W-1:0]  in_len,
  input  wire logic [SYM_W-1:0]  in_sym,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              in_final,
  input  wire logic              cfg_valid,
  input  wire logic [PAD_W-1:0]  cfg_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [SYM_W-1:0]  out_symbol,
  output logic                   out_last,
  output logic                   out_ovf,
  output logic                   out_full
);

  localparam int EFF_LEN_I  = (MAX_CODE_LEN < ACC_W) ? MAX_CODE_LEN : ACC_W;
  localparam int NODE_DEPTH = TABLE_ENTRIES * EFF_LEN_I + 1;
  localparam int PTR_W      = $clog2(NODE_DEPTH);
  localparam int CNT_W      = $clog2(NODE_DEPTH + 1);
  localparam int FILL_W     = $clog2(TABLE_ENTRIES + 1);
  localparam int NODE_W     = 2 * PTR_W + 1 + SYM_W;
  localparam logic [LEN_W-1:0] EFF_LEN = LEN_W'(EFF_LEN_I);

  logic [PAD_W-1:0]  pad_q;
  logic [ACC_W-1:0]  code_q;
  logic [LEN_W-1:0]  len_q;
  logic [SYM_W-1:0]  sym_q;
  logic [BYTE_W-1:0] byte_sreg;
  logic [BCNT_W-1:0] bits_left;
  logic              final_q;

  logic [ACC_W-1:0]  walk_sreg;
  logic [LEN_W-1:0]  walk_cnt;
  logic [PTR_W-1:0]  walk_ptr, walk_ptr_next;
  logic              walk_root;

  logic [PTR_W-1:0]  cur_ptr, cur_ptr_next;
  logic [LEN_W-1:0]  cur_len, cur_len_next;
  logic [ACC_W-1:0]  pending, pending_next;
  logic              check, check_next;

  logic [PTR_W-1:0]  root_c0, root_c1;
  logic [CNT_W-1:0]  node_count;
  logic [FILL_W-1:0] fill_count;

  logic              held_valid, held_ovf, held_full;
  logic [SYM_W-1:0]  held_sym;

  logic              ram_we;
  logic [PTR_W-1:0]  ram_waddr, ram_raddr;
  logic [NODE_W-1:0] ram_wdata, ram_rdata;

  logic [PTR_W-1:0]  rd_c0, rd_c1;
  logic              rd_has;
  logic [SYM_W-1:0]  rd_sym;

  logic              table_full;
  logic [PTR_W-1:0]  alloc_ptr, alloc_ptr_inc;
  logic              walk_bit, walk_fall;
  logic [PTR_W-1:0]  wn_c0, wn_c1, wchild;
  logic [LEN_W-1:0]  load_shamt, pend_shamt;

  logic              hit, ovf, res, take, dbit;
  logic [PTR_W-1:0]  p_ptr, pn_c0, pn_c1, dchild;
  logic [LEN_W-1:0]  p_len;
  logic [ACC_W-1:0]  p_bits;
  logic              out_free, push_step, push_flush, tf_evt, walk_adv;

  pcbd_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODE_DEPTH)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_sym = ram_rdata[SYM_W-1:0];
  assign rd_has = ram_rdata[SYM_W];
  assign rd_c0  = ram_rdata[SYM_W+1 +: PTR_W];
  assign rd_c1  = ram_rdata[SYM_W+1+PTR_W +: PTR_W];

  assign table_full    = (fill_count == FILL_W'(TABLE_ENTRIES));
  assign alloc_ptr     = node_count[PTR_W-1:0];
  assign alloc_ptr_inc = alloc_ptr + PTR_W'(1);

  // trie walk for loads and for rebuilding a dead decode position
  assign walk_bit  = walk_sreg[ACC_W-1];
  assign wn_c0     = walk_root ? root_c0 : rd_c0;
  assign wn_c1     = walk_root ? root_c1 : rd_c1;
  assign wchild    = (!walk_root && (walk_ptr == '0)) ? '0 : (walk_bit ? wn_c1 : wn_c0);
  assign walk_fall = (wchild == '0);
  assign tf_evt    = (cmd.l_walk && walk_fall && table_full) ||
                     (cmd.l_target && !rd_has && table_full);
  assign walk_adv  = (cmd.l_walk && !(walk_fall && table_full)) || cmd.rewalk ||
                     (cmd.l_chain && (walk_cnt != '0));

  assign load_shamt = LEN_W'(ACC_W) - len_q;
  assign pend_shamt = LEN_W'(ACC_W) - cur_len;

  // decode step: check the node reached by the last bit, then take the next bit
  assign hit    = check && (cur_ptr != '0) && rd_has;
  assign ovf    = check && !hit && (cur_len >= EFF_LEN);
  assign res    = hit || ovf;
  assign p_ptr  = res ? '0 : cur_ptr;
  assign p_len  = res ? '0 : cur_len;
  assign p_bits = res ? '0 : pending;
  assign take   = (bits_left != '0);
  assign dbit   = byte_sreg[BYTE_W-1];
  assign pn_c0  = (p_ptr == '0) ? ((p_len == '0) ? root_c0 : '0) : rd_c0;
  assign pn_c1  = (p_ptr == '0) ? ((p_len == '0) ? root_c1 : '0) : rd_c1;
  assign dchild = dbit ? pn_c1 : pn_c0;

  assign out_free   = !out_valid || out_ready;
  assign push_step  = cmd.bits_step && res && held_valid;
  assign push_flush = cmd.flush && held_valid;

  always_comb begin
    cur_ptr_next = cur_ptr;
    cur_len_next = cur_len;
    pending_next = pending;
    check_next   = check;
    if (cmd.bits_step) begin
      if (take) begin
        cur_ptr_next = dchild;
        cur_len_next = p_len + LEN_W'(1);
        pending_next = {p_bits[ACC_W-2:0], dbit};
        check_next   = 1'b1;
      end else begin
        cur_ptr_next = p_ptr;
        cur_len_next = p_len;
        pending_next = p_bits;
        check_next   = 1'b0;
      end
    end else if (cmd.rewalk && (walk_cnt == LEN_W'(1))) begin
      cur_ptr_next = wchild;
    end else if (cmd.d_end) begin
      check_next = 1'b0;
      if (final_q) begin
        cur_ptr_next = '0;
        cur_len_next = '0;
        pending_next = '0;
      end
    end
  end

  always_comb begin
    walk_ptr_next = walk_ptr;
    if (cmd.l_start || cmd.d_start) begin
      walk_ptr_next = '0;
    end else if ((cmd.l_walk && !walk_fall) || cmd.rewalk) begin
      walk_ptr_next = wchild;
    end
  end

  assign ram_raddr = (cmd.l_walk || cmd.rewalk) ? walk_ptr_next : cur_ptr_next;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = walk_ptr;
    ram_wdata = {rd_c1, rd_c0, 1'b1, sym_q};
    if (cmd.l_walk && walk_fall && !table_full && !walk_root) begin
      ram_we    = 1'b1;
      ram_wdata = walk_bit ? {alloc_ptr, rd_c0, rd_has, rd_sym}
                           : {rd_c1, alloc_ptr, rd_has, rd_sym};
    end else if (cmd.l_chain) begin
      ram_we    = 1'b1;
      ram_waddr = alloc_ptr;
      if (walk_cnt == '0) begin
        ram_wdata = {{PTR_W{1'b0}}, {PTR_W{1'b0}}, 1'b1, sym_q};
      end else if (walk_bit) begin
        ram_wdata = {alloc_ptr_inc, {PTR_W{1'b0}}, 1'b0, {SYM_W{1'b0}}};
      end else begin
        ram_wdata = {{PTR_W{1'b0}}, alloc_ptr_inc, 1'b0, {SYM_W{1'b0}}};
      end
    end else if (cmd.l_target && (rd_has || !table_full)) begin
      ram_we    = 1'b1;
      ram_wdata = {rd_c1, rd_c0, 1'b1, sym_q};
    end
  end

  // item fields and walk registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      code_q    <= in_code;
      len_q     <= in_len;
      sym_q     <= in_sym;
      byte_sreg <= in_byte;
      final_q   <= in_final;
      bits_left <= in_final ? BCNT_W'(BYTE_W) - BCNT_W'(pad_q) : BCNT_W'(BYTE_W);
    end else if (cmd.bits_step && take) begin
      byte_sreg <= {byte_sreg[BYTE_W-2:0], 1'b0};
      bits_left <= bits_left - BCNT_W'(1);
    end
    if (cmd.l_start) begin
      walk_sreg <= code_q << load_shamt;
      walk_cnt  <= len_q;
    end else if (cmd.d_start) begin
      walk_sreg <= pending << pend_shamt;
      walk_cnt  <= cur_len;
    end else if (walk_adv) begin
      walk_sreg <= {walk_sreg[ACC_W-2:0], 1'b0};
      walk_cnt  <= walk_cnt - LEN_W'(1);
    end
    walk_ptr <= walk_ptr_next;
    if (cmd.l_start || cmd.d_start) begin
      walk_root <= 1'b1;
    end else if (walk_adv) begin
      walk_root <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_q      <= '0;
      cur_ptr    <= '0;
      cur_len    <= '0;
      pending    <= '0;
      check      <= 1'b0;
      root_c0    <= '0;
      root_c1    <= '0;
      node_count <= CNT_W'(1);
      fill_count <= '0;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        pad_q <= cfg_data;
      end
      cur_ptr <= cur_ptr_next;
      cur_len <= cur_len_next;
      pending <= pending_next;
      check   <= check_next;
      if (cmd.l_walk && walk_fall && !table_full && walk_root) begin
        if (walk_bit) begin
          root_c1 <= alloc_ptr;
        end else begin
          root_c0 <= alloc_ptr;
        end
      end
      if (cmd.l_chain) begin
        node_count <= node_count + CNT_W'(1);
      end
      if ((cmd.l_chain && (walk_cnt == '0)) ||
          (cmd.l_target && !rd_has && !table_full)) begin
        fill_count <= fill_count + FILL_W'(1);
      end
      if (cmd.bits_step && res) begin
        held_valid <= 1'b1;
      end else if (tf_evt) begin
        held_valid <= 1'b1;
      end else if (cmd.flush) begin
        held_valid <= 1'b0;
      end
      if (push_step || push_flush) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bits_step && res) begin
      held_sym  <= hit ? rd_sym : '0;
      held_ovf  <= ovf;
      held_full <= 1'b0;
    end else if (tf_evt) begin
      held_sym  <= '0;
      held_ovf  <= 1'b0;
      held_full <= 1'b1;
    end
    if (push_step || push_flush) begin
      out_symbol <= held_sym;
      out_ovf    <= held_ovf;
      out_full   <= held_full;
      out_last   <= push_flush;
    end
  end

  assign st.len_ok     = (len_q != '0) && (len_q <= EFF_LEN);
  assign st.walk_fall  = walk_fall;
  assign st.walk_last  = (walk_cnt == LEN_W'(1));
  assign st.chain_last = (walk_cnt == '0);
  assign st.table_full = table_full;
  assign st.dead       = (cur_ptr == '0) && (cur_len != '0);
  assign st.bits_done  = (bits_left == '0) && !check;
  assign st.step_ok    = !held_valid || out_free;
  assign st.out_free   = out_free;
  assign st.held_valid = held_valid;

  `PCBD_ASSERT_IMP(a_push_free, clk, rst, push_step || push_flush, out_free)
  `PCBD_ASSERT_IMP(a_len_settled, clk, rst, !check, cur_len < EFF_LEN)
  `PCBD_ASSERT_IMP(a_alloc_bound, clk, rst, cmd.l_chain, node_count < CNT_W'(NODE_DEPTH))

endmodule

`default_nettype wire

// File: rtl/core/pcbd_ctrl.sv
// Controller of the prefix code decoder: item dispatch, load walk,
// bit decode and result flush sequencing.
// Depends on pcbd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pcbd_ctrl import pcbd_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic         op,
  input  wire pcbd_status_t st,
  output pcbd_cmd_t         cmd
);

  pcbd_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (op == OP_DATA) ? S_DSTART : S_LSTART;
        end
      end
      S_LSTART: begin
        state_next = st.len_ok ? S_LWALK : S_IDLE;
      end
      S_LWALK: begin
        if (st.walk_fall) begin
          state_next = st.table_full ? S_FLUSH : S_LCHAIN;
        end else if (st.walk_last) begin
          state_next = S_LTARGET;
        end
      end
      S_LTARGET: begin
        state_next = S_FLUSH;
      end
      S_LCHAIN: begin
        if (st.chain_last) begin
          state_next = S_IDLE;
        end
      end
      S_DSTART: begin
        state_next = st.dead ? S_REWALK : S_BITS;
      end
      S_REWALK: begin
        if (st.walk_last) begin
          state_next = S_BITS;
        end
      end
      S_BITS: begin
        if (st.bits_done) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!st.held_valid || st.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.cap  = in_valid;
      end
      S_LSTART:  cmd.l_start  = 1'b1;
      S_LWALK:   cmd.l_walk   = 1'b1;
      S_LTARGET: cmd.l_target = 1'b1;
      S_LCHAIN:  cmd.l_chain  = 1'b1;
      S_DSTART:  cmd.d_start  = 1'b1;
      S_REWALK:  cmd.rewalk   = 1'b1;
      S_BITS: begin
        cmd.bits_step = !st.bits_done && st.step_ok;
        cmd.d_end     = st.bits_done;
      end
      S_FLUSH:   cmd.flush    = st.out_free;
      default:   cmd          = '0;
    endcase
  end

  `PCBD_ASSERT_NXT(a_bits_exit, clk, rst, (state == S_BITS) && st.bits_done, state == S_FLUSH)

endmodule

`default_nettype wire

// File: rtl/core/prefix_code_bit_decoder.sv
// Prefix code decoder: a load item walks a binary trie in node RAM, one node per cycle.
// Decode runs one bit per cycle unless a held result waits on a busy output;
// each step waits on the registered node RAM read.
// A partial code with no trie path is re-walked first.
// Reset (rst, synchronous) empties the table via root pointers and counts; no RAM clear.
`default_nettype none

module prefix_code_bit_decoder import pcbd_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int MAX_CODE_LEN  = MAX_CODE_LEN_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // code_bits[15:0], code_length[20:16], entry_symbol[28:21], data_byte[36:29], zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // op[0]
  input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
  input  wire logic                   s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // symbol[7:0]
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
  // code_overflow[0], table_full[1]
  output logic      [OUT_TUSER_W-1:0] m_axis_tuser,
  output logic                        m_axis_tlast,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [PAD_W-1:0]       cfg_data
);

  pcbd_cmd_t    cmd;
  pcbd_status_t st;
  logic         ovf, full;

  assign cfg_ready = 1'b1;

  pcbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .op       (s_axis_tuser[0]),
    .st       (st),
    .cmd      (cmd)
  );

  pcbd_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_CODE_LEN  (MAX_CODE_LEN)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .in_code    (s_axis_tdata[IN_CODE_LSB +: ACC_W]),
    .in_len     (s_axis_tdata[IN_LEN_LSB +: LEN_W]),
    .in_sym     (s_axis_tdata[IN_SYM_LSB +: SYM_W]),
    .in_byte    (s_axis_tdata[IN_BYTE_LSB +: BYTE_W]),
    .in_final   (s_axis_tlast),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_symbol (m_axis_tdata),
    .out_last   (m_axis_tlast),
    .out_ovf    (ovf),
    .out_full   (full)
  );

  always_comb begin
    m_axis_tuser               = '0;
    m_axis_tuser[OUT_OVF_BIT]  = ovf;
    m_axis_tuser[OUT_FULL_BIT] = full;
  end

endmodule

`default_nettype wire

// File: verif/tb_prefix_code_bit_decoder.sv
// Testbench for prefix_code_bit_decoder: a directed table, then random code table loads
// and byte streams, every output item checked against a behavioral prefix decoder.
// Depends on pcbd_pkg and the decoder RTL only.
`default_nettype none

module tb_prefix_code_bit_decoder;
  import pcbd_pkg::*;

  localparam int MAX_LEN = (MAX_CODE_LEN_DEF < ACC_W) ? MAX_CODE_LEN_DEF : ACC_W;
  localparam int SETTLE_CYCLES = 64;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD = 400;
  localparam int PHASE_ITEMS = 75;
  localparam int FULL_EXTRA = 8;

  typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_OVERFLOW} exp_kind_t;

  typedef struct packed {
    logic              op;
    logic [ACC_W-1:0]  code_bits;
    logic [LEN_W-1:0]  code_len;
    logic [SYM_W-1:0]  entry_sym;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } pcbd_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             run_last;
    logic             code_overflow;
    logic             table_full;
  } pcbd_out_t;

  typedef struct {
    pcbd_item_t itm;
    exp_kind_t  kind;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata;
  logic [IN_TUSER_W-1:0] s_axis_tuser;
  logic s_axis_tlast;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_valid;
  logic cfg_ready;
  logic [PAD_W-1:0] cfg_data;

  logic             tbl_valid [TABLE_ENTRIES_DEF];
  logic [ACC_W-1:0] tbl_code  [TABLE_ENTRIES_DEF];
  logic [LEN_W-1:0] tbl_len   [TABLE_ENTRIES_DEF];
  logic [SYM_W-1:0] tbl_sym   [TABLE_ENTRIES_DEF];
  int               tbl_fill;
  logic [ACC_W-1:0] acc_bits;
  int               acc_len;
  logic [PAD_W-1:0] pad_cfg;

  pcbd_out_t symbols_due[$];
  pcbd_out_t step_out[$];
  dir_row_t  dir_tbl[$];
  logic [PAD_W-1:0] pad_plan [4];

  int errors = 0;
  int outs_seen = 0;
  int stall_cycles = 0;
  logic idle_on = 1'b1;
  logic long_hold_done = 1'b0;
  pcbd_out_t mon_got, mon_want;

  prefix_code_bit_decoder uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic logic [ACC_W-1:0] len_mask(int l);
    return {ACC_W{1'b1}} >> (ACC_W - l);
  endfunction

  function automatic int find_word(logic [ACC_W-1:0] c, int l);
    for (int i = 0; i < TABLE_ENTRIES_DEF; i++)
      if (tbl_valid[i] && tbl_len[i] == l && tbl_code[i] == c) return i;
    return -1;
  endfunction

  function automatic pcbd_out_t make_out(logic [SYM_W-1:0] sym, logic ovf, logic full);
    pcbd_out_t o;
    o.symbol = sym;
    o.run_last = 1'b0;
    o.code_overflow = ovf;
    o.table_full = full;
    return o;
  endfunction

  function automatic pcbd_item_t rand_item();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(pcbd_item_t)-1:0];
  endfunction

  function automatic dir_row_t row(logic op, logic [ACC_W-1:0] code, logic [LEN_W-1:0] len,
                                   logic [SYM_W-1:0] sym, logic [BYTE_W-1:0] dat, logic fin,
                                   exp_kind_t kind);
    dir_row_t r;
    r.itm.op = op;
    r.itm.code_bits = code;
    r.itm.code_len = len;
    r.itm.entry_sym = sym;
    r.itm.data_byte = dat;
    r.itm.last_byte = fin;
    r.kind = kind;
    return r;
  endfunction

  task automatic predict_symbols(input pcbd_item_t itm);
    int l, hit, nbits;
    logic [ACC_W-1:0] c;
    pcbd_out_t tail;
    step_out.delete();
    if (itm.op == OP_LOAD) begin
      l = itm.code_len;
      if (l == 0 || l > MAX_LEN) return;
      c = itm.code_bits & len_mask(l);
      hit = find_word(c, l);
      if (hit >= 0) begin
        tbl_sym[hit] = itm.entry_sym;
      end else if (tbl_fill >= TABLE_ENTRIES_DEF) begin
        step_out.push_back(make_out('0, 1'b0, 1'b1));
      end else begin
        tbl_valid[tbl_fill] = 1'b1;
        tbl_code[tbl_fill] = c;
        tbl_len[tbl_fill] = l;
        tbl_sym[tbl_fill] = itm.entry_sym;
        tbl_fill++;
      end
    end else begin
      nbits = itm.last_byte ? BYTE_W - int'(pad_cfg) : BYTE_W;
      for (int i = 0; i < nbits; i++) begin
        acc_bits = {acc_bits[ACC_W-2:0], itm.data_byte[BYTE_W-1-i]};
        acc_len++;
        hit = find_word(acc_bits & len_mask(acc_len), acc_len);
        if (hit >= 0) begin
          step_out.push_back(make_out(tbl_sym[hit], 1'b0, 1'b0));
          acc_bits = '0;
          acc_len = 0;
        end else if (acc_len >= MAX_LEN) begin
          step_out.push_back(make_out('0, 1'b1, 1'b0));
          acc_bits = '0;
          acc_len = 0;
        end
      end
      if (itm.last_byte) begin
        acc_bits = '0;
        acc_len = 0;
      end
    end
    if (step_out.size() > 0) begin
      tail = step_out.pop_back();
      tail.run_last = 1'b1;
      step_out.push_back(tail);
    end
  endtask

  task automatic send_item(input pcbd_item_t itm, input exp_kind_t kind);
    logic [IN_TDATA_W-1:0] td;
    pcbd_out_t typed;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    td = '0;
    td[IN_CODE_LSB +: ACC_W] = itm.code_bits;
    td[IN_LEN_LSB +: LEN_W] = itm.code_len;
    td[IN_SYM_LSB +: SYM_W] = itm.entry_sym;
    td[IN_BYTE_LSB +: BYTE_W] = itm.data_byte;
    s_axis_tdata = td;
    s_axis_tuser = itm.op;
    s_axis_tlast = itm.last_byte;
    s_axis_tvalid = 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_symbols(itm);
    case (kind)
      EXP_PREDICT: foreach (step_out[i]) symbols_due.push_back(step_out[i]);
      EXP_OVERFLOW: begin
        typed = make_out('0, 1'b1, 1'b0);
        typed.run_last = 1'b1;
        symbols_due.push_back(typed);
      end
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic write_pad(input logic [PAD_W-1:0] v);
    cfg_data = v;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pad_cfg = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // hold input until all output items are in, then let loads with no result finish
  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (symbols_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_phase(input int n_items);
    pcbd_item_t itm;
    int sent, nbytes, pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        nbytes = $urandom_range(1, 6);
        for (int k = 0; k < nbytes; k++) begin
          itm = rand_item();
          itm.op = OP_DATA;
          // drop the closing byte marker on a few streams
          itm.last_byte = (k == nbytes - 1) ? (pick >= 7) : 1'b0;
          send_item(itm, EXP_PREDICT);
        end
        sent += nbytes;
      end else if (pick < 92) begin
        itm = rand_item();
        itm.op = OP_LOAD;
        itm.code_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2)
                                                    : $urandom_range(3, MAX_LEN);
        send_item(itm, EXP_PREDICT);
        sent++;
      end else begin
        itm = rand_item();
        itm.op = OP_LOAD;
        itm.code_len = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_LEN + 1, 31);
        send_item(itm, EXP_PREDICT);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      mon_got.symbol = m_axis_tdata;
      mon_got.run_last = m_axis_tlast;
      mon_got.code_overflow = m_axis_tuser[OUT_OVF_BIT];
      mon_got.table_full = m_axis_tuser[OUT_FULL_BIT];
      outs_seen++;
      if (symbols_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected item sym=%0h last=%0b ovf=%0b full=%0b", $time,
                 mon_got.symbol, mon_got.run_last, mon_got.code_overflow,
                 mon_got.table_full);
      end else begin
        mon_want = symbols_due.pop_front();
        if (mon_got !== mon_want) begin
          errors++;
          $display("%0t: expected sym=%0h last=%0b ovf=%0b full=%0b, got sym=%0h last=%0b ovf=%0b full=%0b",
                   $time, mon_want.symbol, mon_want.run_last, mon_want.code_overflow,
                   mon_want.table_full, mon_got.symbol, mon_got.run_last,
                   mon_got.code_overflow, mon_got.table_full);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!long_hold_done && outs_seen >= 30) begin
        m_axis_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end else begin
        m_axis_tready = 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  initial begin
    pcbd_item_t itm;
    int extra;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    s_axis_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    for (int i = 0; i < TABLE_ENTRIES_DEF; i++) tbl_valid[i] = 1'b0;
    tbl_fill = 0;
    acc_bits = '0;
    acc_len = 0;
    pad_cfg = '0;

    dir_tbl.push_back(row(OP_DATA, 16'h0000, 5'd0,  8'h00, 8'hFF, 1'b0, EXP_NONE));
    dir_tbl.push_back(row(OP_DATA, 16'h0000, 5'd0,  8'h00, 8'h00, 1'b0, EXP_OVERFLOW));
    dir_tbl.push_back(row(OP_DATA, 16'h0000, 5'd0,  8'h00, 8'hA5, 1'b1, EXP_NONE));
    dir_tbl.push_back(row(OP_LOAD, 16'hFFFF, 5'd0,  8'h11, 8'h00, 1'b0, EXP_NONE));
    dir_tbl.push_back(row(OP_LOAD, 16'h0000, 5'd17, 8'h22, 8'h00, 1'b0, EXP_NONE));
    dir_tbl.push_back(row(OP_LOAD, 16'hFFFF, 5'd31, 8'hFF, 8'h00, 1'b0, EXP_NONE));
    dir_tbl.push_back(row(OP_LOAD, 16'hFFFC, 5'd2,  8'h41, 8'h00, 1'b0, EXP_PREDICT));
    dir_tbl.push_back(row(OP_LOAD, 16'h0001, 5'd2,  8'h42, 8'h00, 1'b0, EXP_PREDICT));
    dir_tbl.push_back(row(OP_LOAD, 16'h0004, 5'd3,  8'h43, 8'h00, 1'b0, EXP_PREDICT));
    dir_tbl.push_back(row(OP_LOAD, 16'h000A, 5'd4,  8'h44, 8'h00, 1'b0, EXP_PREDICT));
    dir_tbl.push_back(row(OP_LOAD, 16'h0016, 5'd5,  8'h00, 8'h00, 1'b0, EXP_PREDICT));
    dir_tbl.push_back(row(OP_LOAD, 16'hFFFF, 5'd16, 8'hFF, 8'h00, 1'b0, EXP_PREDICT));
    dir_tbl.push_back(row(OP_LOAD, 16'hAAA5, 5'd2,  8'h55, 8'h00, 1'b0, EXP_PREDICT));
    dir_tbl.push_back(row(OP_DATA, 16'h0000, 5'd0,  8'h00, 8'h00, 1'b0, EXP_PREDICT));
    dir_tbl.push_back(row(OP_DATA, 16'h0000, 5'd0,  8'h00, 8'h5A, 1'b0, EXP_PREDICT));
    dir_tbl.push_back(row(OP_DATA, 16'h0000, 5'd0,  8'h00, 8'hB0, 1'b0, EXP_PREDICT));
    dir_tbl.push_back(row(OP_DATA, 16'h0000, 5'd0,  8'h00, 8'hFF, 1'b0, EXP_PREDICT));
    dir_tbl.push_back(row(OP_DATA, 16'h0000, 5'd0,  8'h00, 8'hFF, 1'b0, EXP_PREDICT));
    dir_tbl.push_back(row(OP_DATA, 16'h0000, 5'd0,  8'h00, 8'hFF, 1'b1, EXP_PREDICT));
    dir_tbl.push_back(row(OP_DATA, 16'h0000, 5'd0,  8'h00, 8'hC0, 1'b0, EXP_PREDICT));
    dir_tbl.push_back(row(OP_DATA, 16'h0000, 5'd0,  8'h00, 8'h00, 1'b1, EXP_PREDICT));
    dir_tbl.push_back(row(OP_DATA, 16'h0000, 5'd0,  8'h00, 8'h7F, 1'b1, EXP_PREDICT));
    pad_plan = '{3'd7, 3'd2, 3'd5, 3'd1};
    pad_plan[3] = $urandom_range(1, 6);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_pad(3'd0);
    foreach (dir_tbl[i]) send_item(dir_tbl[i].itm, dir_tbl[i].kind);

    foreach (pad_plan[p]) begin
      settle();
      write_pad(pad_plan[p]);
      random_phase(PHASE_ITEMS);
    end

    settle();
    idle_on = 1'b0;
    write_pad(3'd3);
    // fill the table with fresh 16-bit words, then push past capacity
    extra = 0;
    for (int k = 0; extra < FULL_EXTRA; k++) begin
      itm = rand_item();
      itm.op = OP_LOAD;
      itm.code_len = 5'd16;
      itm.code_bits = 16'hC000 + k;
      if (tbl_fill >= TABLE_ENTRIES_DEF) extra++;
      send_item(itm, EXP_PREDICT);
    end
    itm = rand_item();
    itm.op = OP_LOAD;
    itm.code_len = 5'd16;
    itm.code_bits = 16'hFFFF;
    send_item(itm, EXP_PREDICT);
    itm.code_len = 5'd0;
    send_item(itm, EXP_NONE);
    random_phase(24);

    settle();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
